// ===== rtl/core/disk_head_scheduler_top_assert.svh =====
// Assertion macros for the disk head scheduler.
`ifndef DISK_HEAD_SCHEDULER_TOP_ASSERT_SVH
`define DISK_HEAD_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define DHS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("disk head scheduler assertion failed");
// Clocked check that also holds through reset.
`define DHS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("disk head scheduler assertion failed");
`else
`define DHS_ASSERT(label, prop)
`define DHS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/core/dhs_pkg.sv =====
// Shared constants and codes of the disk head scheduler.
package dhs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W       = $clog2(QUEUE_DEPTH + 2);
  localparam int TRK_W       = 16;
  localparam int MOVE_W      = 24;
  localparam int KIND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MOVE_W-1:0] MOVE_MAX     = {MOVE_W{1'b1}};
  localparam logic [TRK_W-1:0]  DISK_END_RST = TRK_W'(200);

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SERVED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  // Scheduling modes (the unused code runs as FCFS)
  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOK = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_END = 2'd2;

endpackage

// ===== rtl/core/dhs_in_if.sv =====
// Request channel: load or run items.
interface dhs_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [dhs_pkg::TRK_W-1:0] track;
  logic [dhs_pkg::TRK_W-1:0] head_start;

  modport source (output valid, output op, output track, output head_start, input ready);
  modport sink   (input valid, input op, input track, input head_start, output ready);
endinterface

// ===== rtl/core/dhs_out_if.sv =====
// Result channel: one beat per head move or status.
interface dhs_out_if;
  logic                       valid;
  logic                       ready;
  logic [dhs_pkg::TRK_W-1:0]  served_track;
  logic [dhs_pkg::KIND_W-1:0] kind;
  logic [dhs_pkg::MOVE_W-1:0] head_travel;
  logic                       last;

  modport source (output valid, output served_track, output kind, output head_travel,
                  output last, input ready);
  modport sink   (input valid, input served_track, input kind, input head_travel,
                  input last, output ready);
endinterface

// ===== rtl/core/dhs_cfg_if.sv =====
// Configuration write channel.
interface dhs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dhs_pkg::CFG_IDX_W-1:0]  index;
  logic [dhs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/disk_head_scheduler_top.sv =====
// Disk head scheduler: request store, FCFS/SCAN/LOOK sequencer and output register.
// Load beat: no result unless the store is full.
// FCFS run: fetch, wait and emit per result. SCAN/LOOK run: per result, one serial pass over
// the stored requests through the read port, then drain, decide, emit; a LOOK turn adds a pass.
// An item is taken only while the sequencer is idle and the output register can take a beat.
// Reset: mode FCFS, sweep up, disk end 200, request count 0; the store is not cleared.
`include "disk_head_scheduler_top_assert.svh"

module disk_head_scheduler_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dhs_in_if.sink    in_i,
  dhs_out_if.source out_o,
  dhs_cfg_if.sink   cfg_i
);
  import dhs_pkg::*;

  localparam int KEY_W = TRK_W + IDX_W;
  localparam int SUM_W = MOVE_W + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FETCH  = 7'b0000010,
    S_FWAIT  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_EDGE   = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic              sweep_up_q;
  logic [TRK_W-1:0]  disk_end_q;

  // Sequencer state
  state_e           st_q;
  phase_e           ph_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] n_q;
  logic [RES_W-1:0] total_q;
  logic [RES_W-1:0] emitted_q;
  logic             fcfs_q;
  logic [IDX_W-1:0] pos_q;
  logic [IDX_W-1:0] idx_q;
  logic [TRK_W-1:0] start_q;
  logic [TRK_W-1:0] head_q;
  logic [MOVE_W-1:0] moved_q;
  logic [TRK_W-1:0] tgt_q;
  logic [KIND_W-1:0] tgt_kind_q;

  // Search state
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             prev_vld_q;
  logic [KEY_W-1:0] prev_key_q;
  logic             best_vld_q;
  logic [KEY_W-1:0] best_key_q;

  // Store
  logic [TRK_W-1:0] mem [QUEUE_DEPTH];
  logic [TRK_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  // Output register
  logic              out_valid_q;
  logic [TRK_W-1:0]  out_trk_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [MOVE_W-1:0] out_move_q;
  logic              out_last_q;

  logic              out_free;
  logic              in_fire;
  logic              cfg_fire;
  logic              full;
  logic              scan_mode;
  logic              push;
  logic [TRK_W-1:0]  push_trk;
  logic [KIND_W-1:0] push_kind;
  logic [MOVE_W-1:0] push_move;
  logic              push_last;
  logic [TRK_W-1:0]  hop_len;
  logic [SUM_W-1:0]  sum;
  logic [MOVE_W-1:0] move_sat;
  logic              emit_last;
  logic              scan_end;

  // Comparator
  logic             asc;
  logic             v_ge;
  logic             v_gt;
  logic             in_range;
  logic [KEY_W-1:0] key;
  logic             after_prev;
  logic             better;
  logic             take;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (st_q == S_IDLE) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire  = cfg_i.valid;
  assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign scan_mode = (mode_q == MODE_SCAN);
  assign mem_we    = in_fire && (in_i.op == OP_LOAD) && !full;
  assign rd_addr   = (st_q == S_FETCH) ? pos_q : idx_q;
  assign scan_end  = (CNT_W'(idx_q) == n_q - CNT_W'(1));

  // Head movement with saturation
  assign hop_len   = (tgt_q > head_q) ? (tgt_q - head_q) : (head_q - tgt_q);
  assign sum       = SUM_W'(moved_q) + SUM_W'(hop_len);
  assign move_sat  = sum[MOVE_W] ? MOVE_MAX : sum[MOVE_W-1:0];
  assign emit_last = (emitted_q == total_q - RES_W'(1));

  // Candidate test on the word read in the previous cycle; key breaks ties by slot
  assign asc  = (sweep_up_q && (ph_q == PH_FIRST)) || (!sweep_up_q && (ph_q == PH_SECOND));
  assign v_ge = (rd_data_q >= start_q);
  assign v_gt = (rd_data_q > start_q);
  assign key  = {rd_data_q, cmp_idx_q};

  always_comb begin
    if (sweep_up_q) begin
      in_range = (ph_q == PH_FIRST) ? v_ge : !v_ge;
    end else begin
      in_range = (ph_q == PH_FIRST) ? !v_gt : v_gt;
    end
    after_prev = !prev_vld_q || (asc ? (key > prev_key_q) : (key < prev_key_q));
    better     = !best_vld_q || (asc ? (key < best_key_q) : (key > best_key_q));
    take       = cmp_vld_q && in_range && after_prev && better;
  end

  // Result beat selection
  always_comb begin
    push      = 1'b0;
    push_trk  = tgt_q;
    push_kind = tgt_kind_q;
    push_move = move_sat;
    push_last = emit_last;
    case (st_q)
      S_IDLE: begin
        if (in_fire && (in_i.op == OP_LOAD) && full) begin
          push      = 1'b1;
          push_trk  = in_i.track;
          push_kind = KIND_REJECT;
          push_move = '0;
          push_last = 1'b1;
        end else if (in_fire && (in_i.op == OP_RUN) && (cnt_q == '0)) begin
          push      = 1'b1;
          push_trk  = in_i.head_start;
          push_kind = KIND_EMPTY;
          push_move = '0;
          push_last = 1'b1;
        end
      end
      S_EMIT: begin
        push = out_free;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[IDX_W-1:0]] <= in_i.track;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_FCFS;
      sweep_up_q <= 1'b1;
      disk_end_q <= DISK_END_RST;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        REG_MODE:     mode_q     <= cfg_i.data[MODE_W-1:0];
        REG_SWEEP_UP: sweep_up_q <= cfg_i.data[0];
        REG_DISK_END: disk_end_q <= cfg_i.data[TRK_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_trk_q  <= push_trk;
      out_kind_q <= push_kind;
      out_move_q <= push_move;
      out_last_q <= push_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.served_track = out_trk_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.head_travel  = out_move_q;
  assign out_o.last         = out_last_q;

  // Search datapath registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (take) begin
      best_key_q <= key;
    end
    if (st_q == S_IDLE && in_fire) begin
      start_q <= in_i.head_start;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      ph_q       <= PH_FIRST;
      cnt_q      <= '0;
      n_q        <= '0;
      total_q    <= '0;
      emitted_q  <= '0;
      fcfs_q     <= 1'b0;
      pos_q      <= '0;
      idx_q      <= '0;
      head_q     <= '0;
      moved_q    <= '0;
      tgt_q      <= '0;
      tgt_kind_q <= KIND_SERVED;
      cmp_vld_q  <= 1'b0;
      prev_vld_q <= 1'b0;
      prev_key_q <= '0;
      best_vld_q <= 1'b0;
    end else begin
      if (take) begin
        best_vld_q <= 1'b1;
      end
      case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.op == OP_LOAD) begin
              if (!full) begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end else begin
              cnt_q <= '0;
              if (cnt_q != '0) begin
                n_q        <= cnt_q;
                total_q    <= RES_W'(cnt_q) + RES_W'(scan_mode);
                emitted_q  <= '0;
                head_q     <= in_i.head_start;
                moved_q    <= '0;
                pos_q      <= '0;
                idx_q      <= '0;
                ph_q       <= PH_FIRST;
                prev_vld_q <= 1'b0;
                best_vld_q <= 1'b0;
                if (mode_q == MODE_SCAN || mode_q == MODE_LOOK) begin
                  fcfs_q <= 1'b0;
                  st_q   <= S_SCAN;
                end else begin
                  fcfs_q <= 1'b1;
                  st_q   <= S_FETCH;
                end
              end
            end
          end
        end
        // FCFS: read the next slot in arrival order
        S_FETCH: begin
          st_q <= S_FWAIT;
        end
        S_FWAIT: begin
          tgt_q      <= rd_data_q;
          tgt_kind_q <= KIND_SERVED;
          st_q       <= S_EMIT;
        end
        // SCAN/LOOK: one pass over the store looking for the next request
        S_SCAN: begin
          cmp_vld_q <= 1'b1;
          idx_q     <= idx_q + IDX_W'(1);
          if (scan_end) begin
            st_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cmp_vld_q <= 1'b0;
          idx_q     <= '0;
          st_q      <= S_DECIDE;
        end
        S_DECIDE: begin
          if (best_vld_q) begin
            tgt_q      <= best_key_q[KEY_W-1:IDX_W];
            tgt_kind_q <= KIND_SERVED;
            prev_key_q <= best_key_q;
            prev_vld_q <= 1'b1;
            st_q       <= S_EMIT;
          end else if (ph_q == PH_FIRST && scan_mode) begin
            // first sweep exhausted: visit the edge
            tgt_q      <= sweep_up_q ? disk_end_q : '0;
            tgt_kind_q <= KIND_EDGE;
            ph_q       <= PH_EDGE;
            st_q       <= S_EMIT;
          end else if (ph_q == PH_FIRST) begin
            ph_q       <= PH_SECOND;
            prev_vld_q <= 1'b0;
            st_q       <= S_SCAN;
          end else begin
            st_q <= S_IDLE;
          end
          best_vld_q <= 1'b0;
        end
        S_EMIT: begin
          if (out_free) begin
            moved_q   <= move_sat;
            head_q    <= tgt_q;
            emitted_q <= emitted_q + RES_W'(1);
            if (emit_last) begin
              st_q <= S_IDLE;
            end else if (fcfs_q) begin
              pos_q <= pos_q + IDX_W'(1);
              st_q  <= S_FETCH;
            end else begin
              if (ph_q == PH_EDGE) begin
                ph_q       <= PH_SECOND;
                prev_vld_q <= 1'b0;
              end
              st_q <= S_SCAN;
            end
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `DHS_ASSERT_ALWAYS(a_cfg_ready, cfg_i.ready)
  `DHS_ASSERT(a_count_bound, cnt_q <= CNT_W'(QUEUE_DEPTH))
  `DHS_ASSERT(a_busy_results_bound, (st_q != S_IDLE) |-> (emitted_q < total_q))
  `DHS_ASSERT(a_last_ends_item, (out_valid_q && out_last_q) |-> (st_q == S_IDLE))
  `DHS_ASSERT(a_edge_only_scan, (st_q == S_EMIT && tgt_kind_q == KIND_EDGE) |-> scan_mode)

endmodule
